/* hdl/assert_macros.svh */
// Assertion macros shared by the RTL of the Sobel gradient block.
// Define NO_ASSERTIONS to compile every macro to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked on every rising clk edge outside reset.
`define SBL_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);
// Checked on every rising clk edge, during reset as well.
`define SBL_ASSERT_NR(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SBL_ASSERT(name, prop, msg)
`define SBL_ASSERT_NR(name, prop, msg)
`endif
`endif

/* hdl/sbl_pkg.sv */
// Shared constants, types and codes of the Sobel gradient block.
// No dependencies; every RTL module of the block uses it.
package sbl_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = 16;
    localparam int PIX_W      = 8;
    localparam int GRAD_W     = 11;
    localparam int CFG_WID_W  = 11;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    // Register indexes, decoded from paddr[2].
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    typedef logic [PIX_W-1:0] pix_t;
    // One window column: entry 0 is the oldest row, entry 2 the current row.
    typedef pix_t [2:0] col_t;
    typedef logic [1:0] win_idx_t;

    localparam win_idx_t WIN_ABOVE = 2'd0;
    localparam win_idx_t WIN_MID   = 2'd1;
    localparam win_idx_t WIN_CUR   = 2'd2;

    // Results one input can cause, in delivery order.
    typedef logic [1:0] res_code_t;
    localparam res_code_t RES_PREV_LEFT = 2'd0;
    localparam res_code_t RES_PREV_HERE = 2'd1;
    localparam res_code_t RES_CUR_LEFT  = 2'd2;
    localparam res_code_t RES_CUR_HERE  = 2'd3;

    typedef struct packed {
        logic             en;
        logic [COL_W-1:0] addr;
        pix_t             up;
        pix_t             mid;
    } ls_wr_t;

endpackage

/* hdl/sbl_line_store.sv */
// Two line memories (the rows two above and one above the current row).
// Depends on sbl_pkg; read data is registered and read-before-write.
module sbl_line_store
(
    input  logic                  clk,
    input  logic                  rd_en,
    input  logic [sbl_pkg::COL_W-1:0] rd_addr,
    input  sbl_pkg::ls_wr_t       wr,
    output sbl_pkg::pix_t         rd_up,
    output sbl_pkg::pix_t         rd_mid
);

    sbl_pkg::pix_t upper_mem [sbl_pkg::MAX_WIDTH];
    sbl_pkg::pix_t middle_mem [sbl_pkg::MAX_WIDTH];
    sbl_pkg::pix_t rd_up_reg;
    sbl_pkg::pix_t rd_mid_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            upper_mem[wr.addr] <= wr.up;
        end
        if (rd_en)
        begin
            rd_up_reg <= upper_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            middle_mem[wr.addr] <= wr.mid;
        end
        if (rd_en)
        begin
            rd_mid_reg <= middle_mem[rd_addr];
        end
    end

    assign rd_up  = rd_up_reg;
    assign rd_mid = rd_mid_reg;

endmodule

/* hdl/sbl_grad_calc.sv */
// Sobel x and y gradients of one 3x3 window given as three columns.
// Depends on sbl_pkg; purely combinational.
module sbl_grad_calc
(
    input  sbl_pkg::col_t     lft,
    input  sbl_pkg::col_t     ctr,
    input  sbl_pkg::col_t     rgt,
    input  sbl_pkg::win_idx_t it,
    input  sbl_pkg::win_idx_t im,
    input  sbl_pkg::win_idx_t ib,
    output logic signed [sbl_pkg::GRAD_W-1:0] grad_x,
    output logic signed [sbl_pkg::GRAD_W-1:0] grad_y
);

    sbl_pkg::pix_t tl, tc, tr, ml, mr, bl, bc, br;
    logic [sbl_pkg::GRAD_W-1:0] pos_x, neg_x, pos_y, neg_y;

    assign tl = lft[it];
    assign tc = ctr[it];
    assign tr = rgt[it];
    assign ml = lft[im];
    assign mr = rgt[im];
    assign bl = lft[ib];
    assign bc = ctr[ib];
    assign br = rgt[ib];

    // Each weighted sum stays below 1024, so the sign bit of every term is zero.
    assign pos_x = sbl_pkg::GRAD_W'(tr) + sbl_pkg::GRAD_W'({mr, 1'b0}) + sbl_pkg::GRAD_W'(br);
    assign neg_x = sbl_pkg::GRAD_W'(tl) + sbl_pkg::GRAD_W'({ml, 1'b0}) + sbl_pkg::GRAD_W'(bl);
    assign pos_y = sbl_pkg::GRAD_W'(bl) + sbl_pkg::GRAD_W'({bc, 1'b0}) + sbl_pkg::GRAD_W'(br);
    assign neg_y = sbl_pkg::GRAD_W'(tl) + sbl_pkg::GRAD_W'({tc, 1'b0}) + sbl_pkg::GRAD_W'(tr);

    assign grad_x = $signed(pos_x - neg_x);
    assign grad_y = $signed(pos_y - neg_y);

endmodule

/* hdl/sobel_gradient_3x3_unit.sv */
// Top level of the streaming 3x3 Sobel gradient block with its APB registers.
// Depends on sbl_pkg, sbl_line_store, sbl_grad_calc and assert_macros.svh.
//
// The block takes one 8-bit luma pixel per clock in raster order while
// in_ready is high, and returns signed x and y gradients with the pixel's
// column and row; edge neighbors repeat the nearest edge pixel, and each
// result belongs to the input that releases it or to the pixel one row up,
// one column left, or both. An accepted pixel is held in a single stage while
// the line memories are read, and that stage hands one result per cycle to
// the output register while it can load: an ordinary pixel owes one result, a
// pixel ending a row two, and on the last row of the frame a pixel past the
// first column owes two, or four at the row end, which flushes the frame; a
// pixel that owes none, as on the first row, still leaves the stage. The line
// memories need no clearing after reset. The user must write frame_width and
// frame_height only while the block is idle; the block does not enforce it.
`include "assert_macros.svh"

module sobel_gradient_3x3_unit
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [sbl_pkg::PADDR_W-1:0]       paddr,
    input  logic [sbl_pkg::PDATA_W-1:0]       pwdata,
    output logic [sbl_pkg::PDATA_W-1:0]       prdata,
    output logic                              pready,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [sbl_pkg::PIX_W-1:0]         luma,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [sbl_pkg::GRAD_W-1:0] grad_x,
    output logic signed [sbl_pkg::GRAD_W-1:0] grad_y,
    output logic [sbl_pkg::COL_W-1:0]         pixel_col,
    output logic [sbl_pkg::ROW_W-1:0]         pixel_row,
    output logic                              run_last,
    output logic                              frame_last
);

    // Configuration registers.
    logic [sbl_pkg::CFG_WID_W-1:0] frame_width_reg;
    logic [sbl_pkg::ROW_W-1:0]     frame_height_reg;
    logic                          cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= sbl_pkg::CFG_WID_W'(640);
            frame_height_reg <= sbl_pkg::ROW_W'(480);
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                sbl_pkg::REG_FRAME_WIDTH:
                    frame_width_reg <= pwdata[sbl_pkg::CFG_WID_W-1:0];
                sbl_pkg::REG_FRAME_HEIGHT:
                    frame_height_reg <= pwdata[sbl_pkg::ROW_W-1:0];
                default:
                    frame_width_reg <= frame_width_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            sbl_pkg::REG_FRAME_WIDTH:
                prdata = sbl_pkg::PDATA_W'(frame_width_reg);
            sbl_pkg::REG_FRAME_HEIGHT:
                prdata = sbl_pkg::PDATA_W'(frame_height_reg);
            default:
                prdata = '0;
        endcase
    end

    // Effective last column and last row, with zero and oversized widths and a zero height clamped.
    logic [sbl_pkg::COL_W-1:0] width_m1;
    logic [sbl_pkg::ROW_W-1:0] height_m1;

    always_comb
    begin
        if (frame_width_reg == '0)
        begin
            width_m1 = '0;
        end
        else if (frame_width_reg > sbl_pkg::CFG_WID_W'(sbl_pkg::MAX_WIDTH))
        begin
            width_m1 = sbl_pkg::COL_W'(sbl_pkg::MAX_WIDTH - 1);
        end
        else
        begin
            width_m1 = sbl_pkg::COL_W'(frame_width_reg - sbl_pkg::CFG_WID_W'(1));
        end
        height_m1 = (frame_height_reg == '0) ? '0 : frame_height_reg - sbl_pkg::ROW_W'(1);
    end

    // Raster position counters, advanced on each accepted input transaction.
    logic [sbl_pkg::COL_W-1:0] col_count_reg;
    logic [sbl_pkg::ROW_W-1:0] row_count_reg;
    logic                      accept;
    logic                      in_lastcol;
    logic                      in_lastrow;

    assign accept     = in_valid && in_ready;
    assign in_lastcol = col_count_reg >= width_m1;
    assign in_lastrow = row_count_reg >= height_m1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
        end
        else if (accept)
        begin
            if (in_lastcol)
            begin
                col_count_reg <= '0;
                row_count_reg <= in_lastrow ? '0 : row_count_reg + sbl_pkg::ROW_W'(1);
            end
            else
            begin
                col_count_reg <= col_count_reg + sbl_pkg::COL_W'(1);
            end
        end
    end

    // Working stage: one pixel with its position and its line memory data.
    logic                      s1_valid_reg;
    logic [sbl_pkg::COL_W-1:0] s1_col_reg;
    logic [sbl_pkg::ROW_W-1:0] s1_row_reg;
    logic                      s1_lastcol_reg;
    logic                      s1_lastrow_reg;
    sbl_pkg::pix_t             s1_luma_reg;
    logic                      fwd_reg;
    sbl_pkg::pix_t             fwd_up_reg;
    sbl_pkg::pix_t             fwd_mid_reg;
    logic [3:0]                done_reg;
    logic [3:0]                done_next;
    logic                      s1_retire;
    logic                      fwd_hit;

    sbl_pkg::pix_t   rd_up;
    sbl_pkg::pix_t   rd_mid;
    sbl_pkg::pix_t   up_eff;
    sbl_pkg::pix_t   mid_eff;
    sbl_pkg::ls_wr_t ls_wr;

    // With a one-pixel row the next pixel reads the entry being written now.
    assign fwd_hit = s1_valid_reg && s1_retire && (s1_col_reg == col_count_reg);
    assign up_eff  = fwd_reg ? fwd_up_reg  : rd_up;
    assign mid_eff = fwd_reg ? fwd_mid_reg : rd_mid;

    assign ls_wr.en   = s1_retire;
    assign ls_wr.addr = s1_col_reg;
    assign ls_wr.up   = mid_eff;
    assign ls_wr.mid  = s1_luma_reg;

    sbl_line_store u_line_store
    (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (col_count_reg),
        .wr      (ls_wr),
        .rd_up   (rd_up),
        .rd_mid  (rd_mid)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
            done_reg     <= '0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                fwd_reg      <= fwd_hit;
            end
            else if (s1_retire)
            begin
                s1_valid_reg <= 1'b0;
            end
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg     <= col_count_reg;
            s1_row_reg     <= row_count_reg;
            s1_lastcol_reg <= in_lastcol;
            s1_lastrow_reg <= in_lastrow;
            s1_luma_reg    <= luma;
            fwd_up_reg     <= mid_eff;
            fwd_mid_reg    <= s1_luma_reg;
        end
    end

    // Sliding window: p2 is two columns back, p1 one column back.
    sbl_pkg::col_t p2_reg;
    sbl_pkg::col_t p1_reg;
    sbl_pkg::col_t cur;

    assign cur[sbl_pkg::WIN_ABOVE] = up_eff;
    assign cur[sbl_pkg::WIN_MID]   = mid_eff;
    assign cur[sbl_pkg::WIN_CUR]   = s1_luma_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p2_reg <= '0;
            p1_reg <= '0;
        end
        else if (s1_retire)
        begin
            p2_reg <= p1_reg;
            p1_reg <= cur;
        end
    end

    // Results due for the pixel in the working stage, one handed out per cycle while the output register can load.
    logic [3:0]         res_mask;
    logic [3:0]         pend;
    logic [3:0]         rest;
    sbl_pkg::res_code_t sel;
    logic               can_load;
    logic               emit;
    logic               is_last;
    logic               col_nz;
    logic               row_nz;

    assign col_nz = s1_col_reg != '0;
    assign row_nz = s1_row_reg != '0;

    always_comb
    begin
        res_mask = '0;
        res_mask[sbl_pkg::RES_PREV_LEFT] = row_nz && col_nz;
        res_mask[sbl_pkg::RES_PREV_HERE] = row_nz && s1_lastcol_reg;
        res_mask[sbl_pkg::RES_CUR_LEFT]  = s1_lastrow_reg && col_nz;
        res_mask[sbl_pkg::RES_CUR_HERE]  = s1_lastrow_reg && s1_lastcol_reg;
    end

    assign pend     = res_mask & ~done_reg;
    assign can_load = !out_valid || out_ready;
    assign emit     = s1_valid_reg && (pend != '0) && can_load;

    always_comb
    begin
        if (pend[sbl_pkg::RES_PREV_LEFT])
        begin
            sel = sbl_pkg::RES_PREV_LEFT;
        end
        else if (pend[sbl_pkg::RES_PREV_HERE])
        begin
            sel = sbl_pkg::RES_PREV_HERE;
        end
        else if (pend[sbl_pkg::RES_CUR_LEFT])
        begin
            sel = sbl_pkg::RES_CUR_LEFT;
        end
        else
        begin
            sel = sbl_pkg::RES_CUR_HERE;
        end
    end

    always_comb
    begin
        rest      = pend;
        rest[sel] = 1'b0;
    end

    assign is_last   = rest == '0;
    assign s1_retire = s1_valid_reg && ((pend == '0) || (emit && is_last));

    always_comb
    begin
        done_next = done_reg;
        if (s1_retire)
        begin
            done_next = '0;
        end
        else if (emit)
        begin
            done_next[sel] = 1'b1;
        end
    end

    // Window column selection for the chosen result.
    logic                      sel_left;
    logic                      sel_cur_row;
    sbl_pkg::col_t             lft;
    sbl_pkg::col_t             ctr;
    sbl_pkg::col_t             rgt;
    sbl_pkg::win_idx_t         it;
    sbl_pkg::win_idx_t         im;
    sbl_pkg::win_idx_t         ib;
    logic [sbl_pkg::COL_W-1:0] res_col;
    logic [sbl_pkg::ROW_W-1:0] res_row;

    assign sel_left    = (sel == sbl_pkg::RES_PREV_LEFT) || (sel == sbl_pkg::RES_CUR_LEFT);
    assign sel_cur_row = (sel == sbl_pkg::RES_CUR_LEFT) || (sel == sbl_pkg::RES_CUR_HERE);

    always_comb
    begin
        if (sel_left)
        begin
            // A result one column back; at column one the left edge repeats.
            lft     = (s1_col_reg == sbl_pkg::COL_W'(1)) ? p1_reg : p2_reg;
            ctr     = p1_reg;
            rgt     = cur;
            res_col = s1_col_reg - sbl_pkg::COL_W'(1);
        end
        else
        begin
            // A result at the row end: the right edge repeats the current column.
            lft     = col_nz ? p1_reg : cur;
            ctr     = cur;
            rgt     = cur;
            res_col = s1_col_reg;
        end
        if (sel_cur_row)
        begin
            // Bottom edge of the frame: the bottom row repeats the middle.
            it      = row_nz ? sbl_pkg::WIN_MID : sbl_pkg::WIN_CUR;
            im      = sbl_pkg::WIN_CUR;
            ib      = sbl_pkg::WIN_CUR;
            res_row = s1_row_reg;
        end
        else
        begin
            it      = (s1_row_reg == sbl_pkg::ROW_W'(1)) ? sbl_pkg::WIN_MID
                                                         : sbl_pkg::WIN_ABOVE;
            im      = sbl_pkg::WIN_MID;
            ib      = sbl_pkg::WIN_CUR;
            res_row = s1_row_reg - sbl_pkg::ROW_W'(1);
        end
    end

    logic signed [sbl_pkg::GRAD_W-1:0] calc_gx;
    logic signed [sbl_pkg::GRAD_W-1:0] calc_gy;

    sbl_grad_calc u_grad_calc
    (
        .lft    (lft),
        .ctr    (ctr),
        .rgt    (rgt),
        .it     (it),
        .im     (im),
        .ib     (ib),
        .grad_x (calc_gx),
        .grad_y (calc_gy)
    );

    // Output register.
    logic                              out_valid_reg;
    logic signed [sbl_pkg::GRAD_W-1:0] grad_x_reg;
    logic signed [sbl_pkg::GRAD_W-1:0] grad_y_reg;
    logic [sbl_pkg::COL_W-1:0]         pixel_col_reg;
    logic [sbl_pkg::ROW_W-1:0]         pixel_row_reg;
    logic                              run_last_reg;
    logic                              frame_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            grad_x_reg     <= calc_gx;
            grad_y_reg     <= calc_gy;
            pixel_col_reg  <= res_col;
            pixel_row_reg  <= res_row;
            run_last_reg   <= is_last;
            frame_last_reg <= sel == sbl_pkg::RES_CUR_HERE;
        end
    end

    assign in_ready   = !s1_valid_reg || s1_retire;
    assign out_valid  = out_valid_reg;
    assign grad_x     = grad_x_reg;
    assign grad_y     = grad_y_reg;
    assign pixel_col  = pixel_col_reg;
    assign pixel_row  = pixel_row_reg;
    assign run_last   = run_last_reg;
    assign frame_last = frame_last_reg;

    // A frame-final result always closes the results of its pixel.
    `SBL_ASSERT(a_frame_last_closes_run, out_valid && frame_last |-> run_last, "frame_last without run_last")
    // Results already delivered are always among those the pixel owes.
    `SBL_ASSERT_NR(a_done_in_mask, s1_valid_reg |-> ((done_reg & ~res_mask) == '0), "delivered result not owed")
    // The same-entry bypass can only come from a one-pixel row.
    `SBL_ASSERT(a_fwd_only_col0, s1_valid_reg && fwd_reg |-> s1_col_reg == '0, "line bypass off column zero")

endmodule
